/* sv/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, register indexes and control types of the PLL divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

   // Field and internal widths.
   localparam int FREQ_W = 30;
   localparam int TGT_W  = 27;
   localparam int NW     = 8;   // N counter, parameters reach 255
   localparam int MW     = 15;  // M counter, parameters reach 32767
   localparam int DW     = 8;   // D counter
   localparam int NUM_W  = 47;  // 2(M+1)f
   localparam int DEN_W  = 17;  // (N+1)(D+1)
   localparam int TDEN_W = 44;  // target times denominator
   localparam int PROD_W = 64;  // error cross products
   localparam int IDX_W  = 3;

   localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_IRC     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_OSC     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_RTC     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_PLL_MIN = 3'd3;
   localparam logic [IDX_W-1:0] CSR_PLL_MAX = 3'd4;

   // Source codes.
   localparam logic [1:0] SRC_IRC = 2'd0;
   localparam logic [1:0] SRC_OSC = 2'd1;
   localparam logic [1:0] SRC_RTC = 2'd2;

   typedef struct packed {
      logic [FREQ_W-1:0] irc;
      logic [FREQ_W-1:0] osc;
      logic [FREQ_W-1:0] rtc;
      logic [FREQ_W-1:0] pll_min;
      logic [FREQ_W-1:0] pll_max;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic dir_step;
      logic dsr_step;
      logic src_step;
      logic div_start;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic dir_last;
      logic dir_hit;
      logic d_done;
      logic s_done;
      logic pipe_busy;
      logic div_done;
   } sts_type;

endpackage

/* sv/pds_divider.sv */
// ----------------------------------------------------------------------------
// pds_divider
// Restoring divider, one quotient bit per cycle, for the achieved frequency.
// ----------------------------------------------------------------------------
module pds_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pds_pkg::NUM_W-1:0] dividend,
   input  logic [pds_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [pds_pkg::NUM_W-1:0] quotient
);
   import pds_pkg::*;

   localparam logic [5:0] LAST = 6'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] dvs_ff, dvs_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;

   // One trial subtraction per cycle; dividend bits shift out as quotient bits shift in.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/pds_datapath.sv */
// ----------------------------------------------------------------------------
// pds_datapath
// Direct-quotient scan, D scan, pipelined candidate search and final division.
// ----------------------------------------------------------------------------
module pds_datapath #(
   parameter int N_LOW  = 0,
   parameter int N_HIGH = 31,
   parameter int M_LOW  = 5,
   parameter int M_HIGH = 511,
   parameter int D_LOW  = 0,
   parameter int D_HIGH = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pds_pkg::cfg_type           cfg,
   input  logic [pds_pkg::TGT_W-1:0]  target,
   input  pds_pkg::cmd_type           cmd,
   output pds_pkg::sts_type           sts,
   output logic [1:0]                 source_select,
   output logic                       pll_on,
   output logic [4:0]                 n_value,
   output logic [8:0]                 m_value,
   output logic [7:0]                 d_value,
   output logic [pds_pkg::FREQ_W-1:0] achieved_freq
);
   import pds_pkg::*;

   localparam logic [NW-1:0] N_LO = NW'(N_LOW);
   localparam logic [NW-1:0] N_HI = NW'(N_HIGH);
   localparam logic [MW-1:0] M_LO = MW'(M_LOW);
   localparam logic [MW-1:0] M_HI = MW'(M_HIGH);
   localparam logic [DW-1:0] D_LO = DW'(D_LOW);
   localparam logic [DW-1:0] D_HI = DW'(D_HIGH);
   localparam logic S_EMPTY = (N_LOW > N_HIGH) || (M_LOW > M_HIGH);
   localparam logic D_EMPTY = D_LOW > D_HIGH;

   function automatic logic [FREQ_W-1:0] src_of(input cfg_type c, input logic [1:0] idx);
      case (idx)
         SRC_IRC: src_of = c.irc;
         SRC_OSC: src_of = c.osc;
         default: src_of = c.rtc;
      endcase
   endfunction

   logic [TGT_W-1:0] t_ff;

   // ---------------- Direct quotient scan ----------------
   logic [7:0]       q_ff;
   logic [2:0]       qhit_ff;
   logic [7:0]       qval_ff [3];
   logic [34:0]      qprod;
   logic [2:0]       qmatch;
   logic [1:0]       dir_sel;

   assign qprod = 35'(t_ff) * 35'(q_ff);

   // A source matches when it is exactly q times a nonzero target.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qmatch[i] = (t_ff != '0) && (qprod == 35'(src_of(cfg, 2'(i))));
      end
   end

   // The last matching source wins.
   always_comb begin
      if (qhit_ff[2]) begin
         dir_sel = SRC_RTC;
      end else if (qhit_ff[1]) begin
         dir_sel = SRC_OSC;
      end else begin
         dir_sel = SRC_IRC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qhit_ff <= '0;
      end else if (cmd.load) begin
         qhit_ff <= '0;
      end else if (cmd.dir_step) begin
         qhit_ff <= qhit_ff | qmatch;
      end
      if (cmd.load) begin
         q_ff <= 8'd1;
         t_ff <= target;
      end else if (cmd.dir_step) begin
         q_ff <= q_ff + 8'd1;
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.dir_step && qmatch[i]) begin
            qval_ff[i] <= q_ff;
         end
      end
   end

   // ---------------- D scan ----------------
   logic [DW-1:0] d_ff;
   logic [DW-1:0] dsel_ff;
   logic          dfound_ff, dover_ff;
   logic [35:0]   dprod;
   logic          d_ok;

   assign dprod = 36'(t_ff) * 36'({1'b0, d_ff} + 9'd1);
   assign d_ok  = (dprod >= 36'(cfg.pll_min)) && (dprod <= 36'(cfg.pll_max));

   always_ff @(posedge clock) begin
      if (reset) begin
         dfound_ff <= 1'b0;
         dover_ff  <= 1'b0;
         dsel_ff   <= '0;
      end else if (cmd.load) begin
         dfound_ff <= 1'b0;
         dover_ff  <= D_EMPTY;
         dsel_ff   <= '0;
      end else if (cmd.dsr_step) begin
         if (d_ok) begin
            dfound_ff <= 1'b1;
            dsel_ff   <= d_ff;
         end else if (d_ff == D_HI) begin
            dover_ff <= 1'b1;
         end
      end
      if (cmd.load) begin
         d_ff <= D_LO;
      end else if (cmd.dsr_step && !d_ok && d_ff != D_HI) begin
         d_ff <= d_ff + DW'(1);
      end
   end

   // ---------------- Candidate counters ----------------
   logic [1:0]    si_ff;
   logic [NW-1:0] sn_ff;
   logic [MW-1:0] sm_ff;
   logic          sover_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sover_ff <= 1'b0;
      end else if (cmd.load) begin
         sover_ff <= S_EMPTY;
      end else if (cmd.src_step && sm_ff == M_HI && sn_ff == N_HI && si_ff == SRC_RTC) begin
         sover_ff <= 1'b1;
      end
      if (cmd.load) begin
         si_ff <= SRC_IRC;
         sn_ff <= N_LO;
         sm_ff <= M_LO;
      end else if (cmd.src_step) begin
         if (sm_ff == M_HI) begin
            sm_ff <= M_LO;
            if (sn_ff == N_HI) begin
               sn_ff <= N_LO;
               if (si_ff != SRC_RTC) begin
                  si_ff <= si_ff + 2'd1;
               end
            end else begin
               sn_ff <= sn_ff + NW'(1);
            end
         end else begin
            sm_ff <= sm_ff + MW'(1);
         end
      end
   end

   // ---------------- Candidate pipeline ----------------
   // Stage A: numerator product and denominator.
   logic              va_ff, vb_ff, vc_ff;
   logic [NUM_W-2:0]  a_num_ff;
   logic [DEN_W-1:0]  a_den_ff, b_den_ff, c_den_ff;
   logic [1:0]        a_i_ff, b_i_ff, c_i_ff;
   logic [NW-1:0]     a_n_ff, b_n_ff, c_n_ff;
   logic [MW-1:0]     a_m_ff, b_m_ff, c_m_ff;
   logic [NUM_W-1:0]  b_num_ff, c_num_ff;
   logic [TDEN_W-1:0] b_tden_ff;
   logic [NUM_W-1:0]  c_err_ff;
   logic [8:0]        np1, dp1;
   logic [NUM_W-1:0]  b_tden_x;

   assign np1      = {1'b0, sn_ff} + 9'd1;
   assign dp1      = {1'b0, dsel_ff} + 9'd1;
   assign b_tden_x = NUM_W'(b_tden_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= cmd.src_step;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      a_num_ff  <= (NUM_W-1)'(46'(src_of(cfg, si_ff)) * 46'({1'b0, sm_ff} + 16'd1));
      a_den_ff  <= DEN_W'(18'(np1) * 18'(dp1));
      a_i_ff    <= si_ff;
      a_n_ff    <= sn_ff;
      a_m_ff    <= sm_ff;
      // Stage B: target times denominator.
      b_tden_ff <= TDEN_W'(TDEN_W'(t_ff) * TDEN_W'(a_den_ff));
      b_num_ff  <= {a_num_ff, 1'b0};
      b_den_ff  <= a_den_ff;
      b_i_ff    <= a_i_ff;
      b_n_ff    <= a_n_ff;
      b_m_ff    <= a_m_ff;
      // Stage C: absolute error.
      c_err_ff  <= (b_num_ff >= b_tden_x) ? b_num_ff - b_tden_x : b_tden_x - b_num_ff;
      c_num_ff  <= b_num_ff;
      c_den_ff  <= b_den_ff;
      c_i_ff    <= b_i_ff;
      c_n_ff    <= b_n_ff;
      c_m_ff    <= b_m_ff;
   end

   // Stage D: exact comparison of err/den against the best so far.
   logic              found_ff;
   logic [NUM_W-1:0]  best_err_ff, best_num_ff;
   logic [DEN_W-1:0]  best_den_ff;
   logic [1:0]        best_i_ff;
   logic [NW-1:0]     best_n_ff;
   logic [MW-1:0]     best_m_ff;
   logic [PROD_W-1:0] lhs, rhs;
   logic              better;

   assign lhs    = PROD_W'(c_err_ff) * PROD_W'(best_den_ff);
   assign rhs    = PROD_W'(best_err_ff) * PROD_W'(c_den_ff);
   assign better = vc_ff && (!found_ff || lhs < rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
      if (cmd.load) begin
         best_err_ff <= '0;
         best_num_ff <= '0;
         best_den_ff <= DEN_W'(1);
         best_i_ff   <= SRC_IRC;
         best_n_ff   <= '0;
         best_m_ff   <= '0;
      end else if (better) begin
         best_err_ff <= c_err_ff;
         best_num_ff <= c_num_ff;
         best_den_ff <= c_den_ff;
         best_i_ff   <= c_i_ff;
         best_n_ff   <= c_n_ff;
         best_m_ff   <= c_m_ff;
      end
   end

   // ---------------- Final division ----------------
   logic              div_done;
   logic [NUM_W-1:0]  quo;

   pds_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (best_num_ff),
      .divisor  (best_den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // ---------------- Status and result fields ----------------
   always_comb begin
      sts.dir_last  = (q_ff == 8'd255);
      sts.dir_hit   = |qhit_ff;
      sts.d_done    = dfound_ff | dover_ff;
      sts.s_done    = sover_ff;
      sts.pipe_busy = va_ff | vb_ff | vc_ff;
      sts.div_done  = div_done;
   end

   always_comb begin
      if (|qhit_ff) begin
         source_select = dir_sel;
         pll_on        = 1'b0;
         n_value       = '0;
         m_value       = '0;
         d_value       = qval_ff[dir_sel] - 8'd1;
         achieved_freq = FREQ_W'(t_ff);
      end else begin
         source_select = best_i_ff;
         pll_on        = 1'b1;
         n_value       = best_n_ff[4:0];
         m_value       = best_m_ff[8:0];
         d_value       = dsel_ff[7:0];
         achieved_freq = (quo > NUM_W'(FREQ_MAX)) ? FREQ_MAX : quo[FREQ_W-1:0];
      end
   end

endmodule

/* sv/pds_ctrl.sv */
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer for the search phases; issues commands and raises the result strobe.
// ----------------------------------------------------------------------------
module pds_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pds_pkg::sts_type sts,
   output pds_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid
);
   import pds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIR,
      ST_CHK,
      ST_DSR,
      ST_SRCH,
      ST_DRAIN,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   // Commands follow directly from the state, gated by start and the status.
   always_comb begin
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.dir_step  = (state_ff == ST_DIR);
      cmd.dsr_step  = (state_ff == ST_DSR) && !sts.d_done;
      cmd.src_step  = (state_ff == ST_SRCH) && !sts.s_done;
      cmd.div_start = (state_ff == ST_DIV_GO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DIR;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DIR: begin
               if (sts.dir_last) begin
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (sts.dir_hit) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_DSR;
               end
            end
            ST_DSR: begin
               if (sts.d_done) begin
                  state_ff <= ST_SRCH;
               end
            end
            ST_SRCH: begin
               if (sts.s_done) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!sts.pipe_busy) begin
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (sts.div_done) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/pll_divider_search_core.sv */
// ----------------------------------------------------------------------------
// pll_divider_search_core
// Picks clock source, PLL use and N, M, D dividers for a target frequency.
//
//  Channel  Ports                          Handshake
//  request  req_target_freq                start high while busy low
//  result   rsp_* fields                   rsp_valid, one cycle, no stall
//  config   csr_index, csr_wdata           csr_we, written at once
//
// The direct scan tries every quotient from 1 to 255; a direct hit gives its beat
// from the check state. Otherwise the D scan tries D from D_LOW up to the first
// fit or D_HIGH, the candidate pipeline takes one candidate per cycle for each
// source, N and M (3*32*507 by default) and drains, then the divider runs.
// The result beat is shown for one cycle while busy is already low.
// Reset is synchronous and restores the default register values.
// ----------------------------------------------------------------------------
module pll_divider_search_core #(
   parameter int N_LOW  = 0,
   parameter int N_HIGH = 31,
   parameter int M_LOW  = 5,
   parameter int M_HIGH = 511,
   parameter int D_LOW  = 0,
   parameter int D_HIGH = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [pds_pkg::TGT_W-1:0]  req_target_freq,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_source_select,
   output logic                       rsp_pll_on,
   output logic [4:0]                 rsp_n_value,
   output logic [8:0]                 rsp_m_value,
   output logic [7:0]                 rsp_d_value,
   output logic [pds_pkg::FREQ_W-1:0] rsp_achieved_freq,
   input  logic                       csr_we,
   input  logic [pds_pkg::IDX_W-1:0]  csr_index,
   input  logic [pds_pkg::FREQ_W-1:0] csr_wdata
);
   import pds_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.irc     <= 30'd4000000;
         cfg_ff.osc     <= 30'd12000000;
         cfg_ff.rtc     <= 30'd32768;
         cfg_ff.pll_min <= 30'd275000000;
         cfg_ff.pll_max <= 30'd550000000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IRC:     cfg_ff.irc     <= csr_wdata;
            CSR_OSC:     cfg_ff.osc     <= csr_wdata;
            CSR_RTC:     cfg_ff.rtc     <= csr_wdata;
            CSR_PLL_MIN: cfg_ff.pll_min <= csr_wdata;
            CSR_PLL_MAX: cfg_ff.pll_max <= csr_wdata;
            default: ;
         endcase
      end
   end

   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pds_datapath #(
      .N_LOW  (N_LOW),
      .N_HIGH (N_HIGH),
      .M_LOW  (M_LOW),
      .M_HIGH (M_HIGH),
      .D_LOW  (D_LOW),
      .D_HIGH (D_HIGH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .target        (req_target_freq),
      .cmd           (cmd),
      .sts           (sts),
      .source_select (rsp_source_select),
      .pll_on        (rsp_pll_on),
      .n_value       (rsp_n_value),
      .m_value       (rsp_m_value),
      .d_value       (rsp_d_value),
      .achieved_freq (rsp_achieved_freq)
   );

`ifndef SYNTH
   // An accepted request always leaves the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // A result beat is never followed directly by another.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   // The direct path carries no PLL settings.
   a_direct_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pll_on |-> rsp_n_value == 5'd0 && rsp_m_value == 9'd0)
      else $error("direct result with nonzero N or M");

   // No result beat while a request is still being worked on.
   a_idle_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// PLL divider search testbench
// Drives target frequencies into the divider search core under several
// register settings and sender idling patterns. Every result beat is checked
// field by field against a predictor of the search held in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pds_pkg::*;

   localparam int          N_LO = 0;
   localparam int          N_HI = 31;
   localparam int          M_LO = 5;
   localparam int          M_HI = 511;
   localparam int          D_LO = 0;
   localparam int          D_HI = 255;
   localparam int          QUOT_MAX = 255;
   localparam longint      CYCLE_LIMIT = 40000000;
   localparam logic [26:0] TGT_MAX = {TGT_W{1'b1}};

   // One planned clock setting, as the result beat carries it.
   typedef struct {
      logic [1:0]        src;
      logic              pll;
      logic [4:0]        n;
      logic [8:0]        m;
      logic [7:0]        d;
      logic [FREQ_W-1:0] freq;
   } plan_type;

   // Scoreboard: register copy, plan predictor and queue of pending plans.
   class divider_plan_board;
      logic [FREQ_W-1:0] freq_reg[5];
      plan_type          pending_plans[$];
      int                mismatches;
      int                plans_checked;
      int                direct_plans;

      function new();
         freq_reg[CSR_IRC]     = 30'd4000000;
         freq_reg[CSR_OSC]     = 30'd12000000;
         freq_reg[CSR_RTC]     = 30'd32768;
         freq_reg[CSR_PLL_MIN] = 30'd275000000;
         freq_reg[CSR_PLL_MAX] = 30'd550000000;
         mismatches = 0;
         plans_checked = 0;
         direct_plans = 0;
      endfunction

      function plan_type plan_for(logic [TGT_W-1:0] target);
         plan_type          p;
         longint unsigned   t, s[3], quot, prod, den, tden, num, err;
         longint unsigned   best_err, best_den, best_freq;
         bit                direct, found;
         int                dsel;
         t = target;
         for (int i = 0; i < 3; i++) s[i] = freq_reg[i];
         direct = 0;
         quot = 0;
         p.src = SRC_IRC;
         // Direct division: the last source that is a small exact multiple.
         if (t != 0) begin
            for (int i = 0; i < 3; i++) begin
               if (s[i] >= t && s[i] % t == 0 && s[i] / t <= QUOT_MAX) begin
                  direct = 1;
                  p.src = i[1:0];
                  quot = s[i] / t;
               end
            end
         end
         if (direct) begin
            p.pll = 1'b0;
            p.n = '0;
            p.m = '0;
            p.d = 8'(quot - 1);
            p.freq = FREQ_W'(t);
            direct_plans++;
            return p;
         end
         // First D that puts the PLL output inside the window.
         dsel = 0;
         for (int d = D_LO; d <= D_HI; d++) begin
            prod = t * longint'(d + 1);
            if (prod >= freq_reg[CSR_PLL_MIN] && prod <= freq_reg[CSR_PLL_MAX]) begin
               dsel = d;
               break;
            end
         end
         // Exhaustive search, keeping the first least error.
         found = 0;
         best_err = 0;
         best_den = 1;
         best_freq = 0;
         p.src = SRC_IRC;
         p.n = '0;
         p.m = '0;
         for (int i = 0; i < 3; i++) begin
            for (int n = N_LO; n <= N_HI; n++) begin
               den = longint'(n + 1) * longint'(dsel + 1);
               tden = t * den;
               for (int m = M_LO; m <= M_HI; m++) begin
                  num = 2 * longint'(m + 1) * s[i];
                  err = (num >= tden) ? num - tden : tden - num;
                  if (!found || err * best_den < best_err * den) begin
                     found = 1;
                     best_err = err;
                     best_den = den;
                     best_freq = num / den;
                     p.src = i[1:0];
                     p.n = n[4:0];
                     p.m = m[8:0];
                  end
               end
            end
         end
         if (best_freq > FREQ_MAX) best_freq = FREQ_MAX;
         p.pll = 1'b1;
         p.d = dsel[7:0];
         p.freq = FREQ_W'(best_freq);
         return p;
      endfunction

      function void note_request(logic [TGT_W-1:0] target);
         pending_plans.push_back(plan_for(target));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_plan(plan_type got);
         plan_type want;
         if (pending_plans.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
            return;
         end
         want = pending_plans.pop_front();
         plans_checked++;
         if (got.src !== want.src) report_mismatch("source_select", got.src, want.src);
         if (got.pll !== want.pll) report_mismatch("pll_on", got.pll, want.pll);
         if (got.n !== want.n) report_mismatch("n_value", got.n, want.n);
         if (got.m !== want.m) report_mismatch("m_value", got.m, want.m);
         if (got.d !== want.d) report_mismatch("d_value", got.d, want.d);
         if (got.freq !== want.freq) report_mismatch("achieved_freq", got.freq, want.freq);
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [TGT_W-1:0]  req_target_freq = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_source_select;
   logic              rsp_pll_on;
   logic [4:0]        rsp_n_value;
   logic [8:0]        rsp_m_value;
   logic [7:0]        rsp_d_value;
   logic [FREQ_W-1:0] rsp_achieved_freq;
   logic              csr_we = 1'b0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [FREQ_W-1:0] csr_wdata = '0;

   divider_plan_board board = new();
   longint            cycles = 0;
   int                idle_pct = 0;
   int                beats_sent = 0;

   pll_divider_search_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_freq(req_target_freq),
      .rsp_valid(rsp_valid), .rsp_source_select(rsp_source_select),
      .rsp_pll_on(rsp_pll_on), .rsp_n_value(rsp_n_value),
      .rsp_m_value(rsp_m_value), .rsp_d_value(rsp_d_value),
      .rsp_achieved_freq(rsp_achieved_freq),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result monitor and run limit.
   always @(posedge clock) begin
      plan_type got;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         got.src = rsp_source_select;
         got.pll = rsp_pll_on;
         got.n = rsp_n_value;
         got.m = rsp_m_value;
         got.d = rsp_d_value;
         got.freq = rsp_achieved_freq;
         board.check_plan(got);
      end
   end

   // Present one target and hold it until the core takes the beat.
   task send_target(logic [TGT_W-1:0] target);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_target_freq <= target;
      do @(posedge clock); while (busy);
      board.note_request(target);
      beats_sent++;
   endtask

   // Stop sending and wait until every pending plan has come back.
   task drain_plans();
      start <= 1'b0;
      while (board.pending_plans.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(logic [IDX_W-1:0] idx, logic [FREQ_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.freq_reg[idx] = value;
   endtask

   task load_regs(logic [FREQ_W-1:0] irc, logic [FREQ_W-1:0] osc, logic [FREQ_W-1:0] rtc,
                  logic [FREQ_W-1:0] lo, logic [FREQ_W-1:0] hi);
      drain_plans();
      write_reg(CSR_IRC, irc);
      write_reg(CSR_OSC, osc);
      write_reg(CSR_RTC, rtc);
      write_reg(CSR_PLL_MIN, lo);
      write_reg(CSR_PLL_MAX, hi);
      @(posedge clock);
   endtask

   // Random targets: mostly exact fractions of a source, some arbitrary.
   task random_targets(int count, bit pressure);
      logic [TGT_W-1:0] t;
      longint unsigned  s;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 70) begin
            s = board.freq_reg[$urandom_range(2)];
            t = TGT_W'(s / longint'($urandom_range(QUOT_MAX, 1)));
            if (t == 0) t = 1;
         end else begin
            t = TGT_W'($urandom);
         end
         if (pressure && k < 3) drain_plans();
         send_target(t);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed targets under the reset register values.
      send_target('0);
      send_target(27'd1);
      send_target(TGT_MAX);
      send_target(27'd4000000);
      send_target(27'd12000000);
      send_target(27'd32768);
      send_target(27'd16000);
      send_target(27'd128);
      send_target(27'd100000000);
      send_target(27'd48000);
      random_targets(20, 1'b1);

      // Moderate random register values, sender idling often.
      idle_pct = 68;
      load_regs(30'($urandom_range(50000000, 1000)), 30'($urandom_range(50000000, 1000)),
                30'($urandom_range(100000, 1000)), 30'($urandom_range(300000000, 100000000)),
                30'($urandom_range(900000000, 300000000)));
      random_targets(30, 1'b0);

      // Register extremes: full-scale and tiny sources, widest window.
      idle_pct = 12;
      load_regs(FREQ_MAX, '0, 30'd1, '0, FREQ_MAX);
      send_target(TGT_MAX);
      send_target(27'd1);
      send_target('0);
      random_targets(15, 1'b0);

      // Inverted window so no D qualifies, with no idling.
      idle_pct = 0;
      load_regs(30'd24000000, 30'd25000000, 30'd32768, FREQ_MAX, '0);
      random_targets(25, 1'b0);

      drain_plans();
      repeat (300) @(posedge clock);
      $display("Sent %0d targets over four register settings, %0d planned directly.",
               beats_sent, board.direct_plans);
      $display("Checked %0d result beats, %0d mismatches.", board.plans_checked,
               board.mismatches);
      if (board.mismatches == 0 && board.pending_plans.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
